// ----- hdl/qcw_pkg.sv -----
// ----------------------------------------------------------------------------
// qcw_pkg
// Types and constants shared by the quadrature counter with wrap limits.
// ----------------------------------------------------------------------------
package qcw_pkg;

	localparam int unsigned CountW = 16;

	// The kind of input request: a sample of the lines or a load of the count.
	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_LOAD   = 1'b1
	} op_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_UPPER = 1'b0,
		REG_LOWER = 1'b1
	} reg_idx_t;

	typedef logic signed [CountW-1:0] count_t;
	typedef logic signed [1:0]        step_t;

	localparam step_t STEP_NONE = 2'sd0;
	localparam step_t STEP_UP   = 2'sd1;
	localparam step_t STEP_DOWN = -2'sd1;

	localparam count_t UPPER_RESET = 16'sh7FFF;
	localparam count_t LOWER_RESET = 16'sh8000;

	typedef struct packed {
		op_t    operation;
		logic   line_a;
		logic   line_b;
		count_t load_value;
	} item_t;

	typedef struct packed {
		logic     wr_en;
		reg_idx_t index;
		count_t   data;
	} cfg_wr_t;

endpackage

// ----- hdl/qcw_track.sv -----
// ----------------------------------------------------------------------------
// qcw_track
// Holds the count, the pending step, the previous line levels and the limit
// registers, and works out the updated count for each accepted request.
// ----------------------------------------------------------------------------
module qcw_track (
	input  logic             clk,
	input  logic             arst_n,
	input  qcw_pkg::cfg_wr_t cfg,
	input  logic             item_en,
	input  qcw_pkg::item_t   item,
	output qcw_pkg::count_t  position_next
);
	import qcw_pkg::*;

	count_t upper_q;
	count_t lower_q;
	count_t count_q;
	step_t  pending_q;
	logic   last_a_q;
	logic   last_b_q;

	logic   fall_a;
	logic   fall_b;
	step_t  pending_mid;
	step_t  pending_d;
	step_t  apply_step;
	logic signed [CountW:0] sum;
	logic signed [CountW:0] upper_ext;
	logic signed [CountW:0] lower_ext;
	count_t wrapped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_RESET;
			lower_q <= LOWER_RESET;
		end else if (cfg.wr_en) begin
			unique case (cfg.index)
				REG_UPPER: upper_q <= cfg.data;
				REG_LOWER: lower_q <= cfg.data;
				default:   upper_q <= upper_q;
			endcase
		end
	end

	assign fall_a = last_a_q & ~item.line_a;
	assign fall_b = last_b_q & ~item.line_b;

	// A falling edge on both lines means both are low, so the A edge applies
	// the old pending step and clears it; the B edge then has nothing to add.
	// At most one nonzero step is applied per sample.
	always_comb begin
		pending_mid = fall_a ? (item.line_b ? STEP_UP : STEP_NONE) : pending_q;
		pending_d   = fall_b ? (item.line_a ? STEP_DOWN : STEP_NONE) : pending_mid;
		if (fall_a && !item.line_b) begin
			apply_step = pending_q;
		end else if (fall_b && !item.line_a) begin
			apply_step = pending_mid;
		end else begin
			apply_step = STEP_NONE;
		end
	end

	assign sum       = {count_q[CountW-1], count_q} + {{(CountW-1){apply_step[1]}}, apply_step};
	assign upper_ext = {upper_q[CountW-1], upper_q};
	assign lower_ext = {lower_q[CountW-1], lower_q};

	always_comb begin
		if (apply_step == STEP_NONE) begin
			wrapped = count_q;
		end else if (sum <= upper_ext && sum >= lower_ext) begin
			wrapped = sum[CountW-1:0];
		end else if (sum > upper_ext) begin
			wrapped = lower_q;
		end else begin
			wrapped = upper_q;
		end
	end

	assign position_next = (item.operation == OP_LOAD) ? item.load_value : wrapped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pending_q <= STEP_NONE;
			last_a_q  <= 1'b1;
			last_b_q  <= 1'b1;
		end else if (item_en) begin
			count_q <= position_next;
			if (item.operation == OP_SAMPLE) begin
				pending_q <= pending_d;
				last_a_q  <= item.line_a;
				last_b_q  <= item.line_b;
			end
		end
	end

	a_pending_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != -2'sd2)
		else $error("pending step holds an illegal code");

	a_load_sets_count: assert property (@(posedge clk) disable iff (!arst_n)
		item_en && item.operation == OP_LOAD |=> count_q == $past(item.load_value))
		else $error("load request did not set the count");

	a_load_keeps_lines: assert property (@(posedge clk) disable iff (!arst_n)
		item_en && item.operation == OP_LOAD |=> $stable(pending_q) && $stable(last_a_q)
			&& $stable(last_b_q))
		else $error("load request disturbed the edge tracking state");

endmodule

// ----- hdl/quadrature_counter_with_wrap_core.sv -----
// Each accepted request's position is registered before it shows on m_tdata.
// One request per cycle while s_tready is high; the count update is one add and compare.
// A two-entry output stage takes one more request while m_tready is low.
// Reset (arst_n low, asynchronous): count 0, no pending step, both lines taken as high,
// limits at the full signed 16-bit range, output stage empty.
// ----------------------------------------------------------------------------
// quadrature_counter_with_wrap_core
// Quadrature encoder position counter with wrap-around limits and load command.
// ----------------------------------------------------------------------------
module quadrature_counter_with_wrap_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // [0] line_a, [1] line_b, [17:2] load_value
	input  logic                 s_tuser,   // [0] operation
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [15:0] position
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data
);
	import qcw_pkg::*;

	item_t   item;
	cfg_wr_t cfg;
	logic    in_acc;
	logic    out_free;
	count_t  position_next;
	count_t  out_q;
	logic    out_valid_q;
	count_t  skid_q;
	logic    skid_valid_q;

	assign cfg_ready = 1'b1;
	assign cfg.wr_en = cfg_valid;
	assign cfg.index = reg_idx_t'(cfg_index);
	assign cfg.data  = count_t'(cfg_data);

	assign item.operation  = op_t'(s_tuser);
	assign item.line_a     = s_tdata[0];
	assign item.line_b     = s_tdata[1];
	assign item.load_value = count_t'(s_tdata[17:2]);

	assign s_tready = ~skid_valid_q;
	assign in_acc   = s_tvalid & s_tready;
	assign out_free = ~out_valid_q | m_tready;

	qcw_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.item_en       (in_acc),
		.item          (item),
		.position_next (position_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | in_acc;
			skid_valid_q <= 1'b0;
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : position_next;
		end else if (in_acc) begin
			skid_q <= position_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register is empty");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted request produced no result");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && out_valid_q && !m_tready |=> skid_valid_q && !s_tready)
		else $error("request accepted under stall was not parked");

endmodule
